// ===== sv/gse_pkg.sv =====
// Shared types, constants and the stick conversion function for the gamepad
// sample to events unit. No dependencies.
`default_nettype none

package gse_pkg;

   localparam int FULL_SCALE   = 32768;
   localparam int BUTTON_COUNT = 16;
   localparam int AXIS_COUNT   = 4;
   localparam int AXIS_W       = 2;
   localparam int SLOT_COUNT   = BUTTON_COUNT + AXIS_COUNT;
   localparam int SLOT_W       = $clog2(SLOT_COUNT);

   localparam logic [15:0] BUTTON_MASK = 16'((32'd1 << BUTTON_COUNT) - 32'd1);
   localparam logic signed [16:0] AXIS_MAX = 17'(FULL_SCALE - 1);
   localparam logic signed [16:0] AXIS_MIN = 17'(-FULL_SCALE);

   localparam logic [7:0] DZ_LOW_RESET  = 8'd116;
   localparam logic [7:0] DZ_HIGH_RESET = 8'd140;
   localparam logic [7:0] STICK_CENTER  = 8'd128;

   typedef enum logic [0:0] {
      CSR_DZ_LOW  = 1'b0,
      CSR_DZ_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_AXIS    = 2'd2
   } event_kind_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic              load;
      logic              emit;
      logic [SLOT_W-1:0] slot;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_pending;
      logic out_free;
   } dp_status_type;

   // Map a raw stick byte to a full-scale axis value, zero inside the dead zone.
   function automatic logic signed [15:0] stick_to_axis(input logic [7:0] raw,
                                                        input logic [7:0] dz_low,
                                                        input logic [7:0] dz_high);
      logic signed [8:0]  centered;
      logic signed [16:0] scaled;
      logic signed [15:0] result;
      centered = $signed({1'b0, raw}) - $signed({1'b0, STICK_CENTER});
      scaled   = $signed({centered, 8'd0});
      if (raw >= dz_low && raw <= dz_high) begin
         result = 16'sd0;
      end else if (scaled > AXIS_MAX) begin
         result = AXIS_MAX[15:0];
      end else if (scaled < AXIS_MIN) begin
         result = AXIS_MIN[15:0];
      end else begin
         result = scaled[15:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== sv/gamepad_sample_to_events_unit.sv =====
// Gamepad sample to events unit: one sample in, zero to twenty events out.
// A new sample is accepted only in idle, after the sequencer has walked all
// sixteen button slots and four axis slots, one slot per cycle; it stalls on a
// slot while the result register is full and stalled. An event passes the pending
// slot mask and then the result register. Reset (synchronous, active high) clears
// button and axis state, sets the dead zone to 116..140 and empties the result register.
`default_nettype none

module gamepad_sample_to_events_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration write channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [0:0]          csr_index,
   input  wire logic [7:0]          csr_data,
   // sample input channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_pad_connected,
   input  wire logic [15:0]         req_button_bits,
   input  wire logic [7:0]          req_left_x,
   input  wire logic [7:0]          req_left_y,
   input  wire logic [7:0]          req_right_x,
   input  wire logic [7:0]          req_right_y,
   // event output channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_event_kind,
   output logic [3:0]               rsp_event_index,
   output logic signed [15:0]       rsp_axis_value,
   output logic signed [16:0]       rsp_axis_delta,
   output logic                     rsp_last_event
);
   import gse_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The user must write configuration only while idle (not enforced); every write is taken at once.
   assign csr_ready = 1'b1;

   // Sequencer: accept a transaction in idle, then step through the slots,
   // holding on a due slot until the result register frees up.
   gse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: convert the sample on load, keep the pending slot mask, update
   // stored axis values as their events leave, and drive the result register.
   gse_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_pad_connected (req_pad_connected),
      .req_button_bits   (req_button_bits),
      .req_left_x        (req_left_x),
      .req_left_y        (req_left_y),
      .req_right_x       (req_right_x),
      .req_right_y       (req_right_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_index   (rsp_event_index),
      .rsp_axis_value    (rsp_axis_value),
      .rsp_axis_delta    (rsp_axis_delta),
      .rsp_last_event    (rsp_last_event)
   );

endmodule

`default_nettype wire

// ===== sv/gse_ctrl.sv =====
// Sequencer for the gamepad sample to events unit: loads a sample, then walks
// the button and axis slots. Depends on gse_pkg.
`default_nettype none

module gse_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire gse_pkg::dp_status_type status,
   output gse_pkg::ctrl_cmd_type      cmd
);
   import gse_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              step;
   logic              last_slot;

   // advance past a slot when nothing is due there or the output can take it
   assign step      = !status.slot_pending || status.out_free;
   assign last_slot = (slot_ff == SLOT_W'(SLOT_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            slot_in = '0;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step) begin
               if (last_slot) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd.load  = 1'b0;
      cmd.emit  = 1'b0;
      cmd.slot  = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.emit = status.slot_pending && status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/gse_datapath.sv =====
// Datapath of the gamepad sample to events unit: dead zone registers, button
// and axis state, pending slot mask and the result register. Depends on gse_pkg.
`default_nettype none

module gse_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gse_pkg::ctrl_cmd_type  cmd,
   output gse_pkg::dp_status_type      status,
   input  wire logic                   csr_valid,
   input  wire logic [0:0]             csr_index,
   input  wire logic [7:0]             csr_data,
   input  wire logic                   req_pad_connected,
   input  wire logic [15:0]            req_button_bits,
   input  wire logic [7:0]             req_left_x,
   input  wire logic [7:0]             req_left_y,
   input  wire logic [7:0]             req_right_x,
   input  wire logic [7:0]             req_right_y,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_event_kind,
   output logic [3:0]                  rsp_event_index,
   output logic signed [15:0]          rsp_axis_value,
   output logic signed [16:0]          rsp_axis_delta,
   output logic                        rsp_last_event
);
   import gse_pkg::*;

   logic [7:0]             dz_low_ff, dz_high_ff;
   logic [15:0]            buttons_ff;
   logic signed [15:0]     axis_ff [AXIS_COUNT];
   logic signed [15:0]     axis_new_ff [AXIS_COUNT];
   logic [SLOT_COUNT-1:0]  pending_ff, pending_cleared;

   logic [15:0]            buttons_now;
   logic signed [15:0]     axis_now [AXIS_COUNT];
   logic [7:0]             raw [AXIS_COUNT];
   logic [AXIS_COUNT-1:0]  axis_changed;

   logic                   is_button;
   logic [AXIS_W-1:0]      axis_sel;
   logic signed [15:0]     sel_new, sel_old;
   logic signed [16:0]     sel_delta;

   logic                   rsp_valid_ff;
   event_kind_type         kind_ff;
   logic [3:0]             index_ff;
   logic signed [15:0]     value_ff;
   logic signed [16:0]     delta_ff;
   logic                   last_ff;

   // sample conversion, a disconnected pad reads as all zero
   assign raw[0] = req_left_x;
   assign raw[1] = req_left_y;
   assign raw[2] = req_right_x;
   assign raw[3] = req_right_y;
   assign buttons_now = req_pad_connected ? (req_button_bits & BUTTON_MASK) : 16'd0;

   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         axis_now[i] = req_pad_connected ?
                       stick_to_axis(raw[i], dz_low_ff, dz_high_ff) : 16'sd0;
         axis_changed[i] = (axis_now[i] != axis_ff[i]);
      end
   end

   // slot decode
   assign is_button = (cmd.slot < SLOT_W'(BUTTON_COUNT));
   assign axis_sel  = AXIS_W'(cmd.slot - SLOT_W'(BUTTON_COUNT));
   assign sel_new   = axis_new_ff[axis_sel];
   assign sel_old   = axis_ff[axis_sel];
   assign sel_delta = {sel_new[15], sel_new} - {sel_old[15], sel_old};

   always_comb begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         pending_cleared[s] = pending_ff[s] && (cmd.slot != SLOT_W'(s));
      end
   end

   assign status.slot_pending = pending_ff[cmd.slot];
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_low_ff  <= DZ_LOW_RESET;
         dz_high_ff <= DZ_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DZ_LOW:  dz_low_ff  <= csr_data;
            CSR_DZ_HIGH: dz_high_ff <= csr_data;
            default: begin
               dz_low_ff <= dz_low_ff;
            end
         endcase
      end
   end

   // stored state and pending mask
   always_ff @(posedge clock) begin
      if (reset) begin
         buttons_ff <= '0;
         pending_ff <= '0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            axis_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         buttons_ff <= buttons_now;
         pending_ff <= {axis_changed, (buttons_now[BUTTON_COUNT-1:0]
                                       ^ buttons_ff[BUTTON_COUNT-1:0])};
      end else if (cmd.emit) begin
         pending_ff <= pending_cleared;
         if (!is_button) begin
            axis_ff[axis_sel] <= sel_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            axis_new_ff[i] <= axis_now[i];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         last_ff <= (pending_cleared == '0);
         if (is_button) begin
            kind_ff  <= buttons_ff[cmd.slot[3:0]] ? KIND_PRESS : KIND_RELEASE;
            index_ff <= 4'(cmd.slot);
            value_ff <= '0;
            delta_ff <= '0;
         end else begin
            kind_ff  <= KIND_AXIS;
            index_ff <= 4'(axis_sel);
            value_ff <= sel_new;
            delta_ff <= sel_delta;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_index = index_ff;
   assign rsp_axis_value  = value_ff;
   assign rsp_axis_delta  = delta_ff;
   assign rsp_last_event  = last_ff;

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted event did not reach the result register");

   a_emit_only_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (pending_ff[cmd.slot] && status.out_free))
      else $error("event emitted for an idle slot or into a full register");

   a_last_clears_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (pending_cleared == '0)) |=> (pending_ff == '0 && rsp_last_event))
      else $error("last event marked while events remain");

endmodule

`default_nettype wire
